/* design/dpb_pkg.sv */
// Package for the depth pixel back-projection block.
// Holds limits, register indexes and the types shared by the front, queue and back.
// No dependencies.
package dpb_pkg;

  localparam int unsigned MAX_DIM      = 4096;
  localparam int unsigned MIN_DEPTH_MM = 100;
  localparam int unsigned MAX_DEPTH_MM = 50000;
  localparam int unsigned MAX_STEP     = 16;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_STRIDE       = 3'd2;
  localparam logic [2:0] REG_INV_FOCAL_X  = 3'd3;
  localparam logic [2:0] REG_INV_FOCAL_Y  = 3'd4;
  localparam logic [2:0] REG_CENTER_X     = 3'd5;
  localparam logic [2:0] REG_CENTER_Y     = 3'd6;

  typedef struct packed {
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [4:0]  stride;
    logic [23:0] inv_focal_x;
    logic [23:0] inv_focal_y;
    logic [15:0] center_x;
    logic [15:0] center_y;
  } cfg_t;

  // One kept pixel, classified and ready for projection.
  typedef struct packed {
    logic [15:0] mag_x;
    logic        neg_x;
    logic [15:0] mag_y;
    logic        neg_y;
    logic [15:0] depth;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        valid;
    logic        last;
  } point_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* design/dpb_front.sv */
// Front part: raster position counters, subsampling and depth classification.
// Depends on dpb_pkg; pushes one request per kept pixel into dpb_queue.
module dpb_front
  import dpb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] depth_mm,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        frame_start,
  input  q_stat_t     q_stat,
  output logic        push,
  output point_req_t  push_data
);

  logic [11:0] column_count, row_count;
  logic [3:0]  column_phase, row_phase;
  logic [11:0] column_count_next, row_count_next;
  logic [3:0]  column_phase_next, row_phase_next;

  logic [11:0] cc, rc;
  logic [3:0]  cp, rp;
  logic [12:0] w, h;
  logic [4:0]  st;
  logic [12:0] cc_inc, rc_inc;
  logic [4:0]  cp_inc, rp_inc;
  logic [16:0] off_x, off_y, neg_off_x, neg_off_y;
  logic        accept, kept, in_range;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    w  = (cfg.image_width == '0) ? 13'd1 :
         (cfg.image_width > 13'(MAX_DIM)) ? 13'(MAX_DIM) : cfg.image_width;
    h  = (cfg.image_height == '0) ? 13'd1 :
         (cfg.image_height > 13'(MAX_DIM)) ? 13'(MAX_DIM) : cfg.image_height;
    st = (cfg.stride == '0) ? 5'd1 :
         (cfg.stride > 5'(MAX_STEP)) ? 5'(MAX_STEP) : cfg.stride;
  end

  always_comb begin
    cc = frame_start ? '0 : column_count;
    rc = frame_start ? '0 : row_count;
    cp = frame_start ? '0 : column_phase;
    rp = frame_start ? '0 : row_phase;

    cc_inc = {1'b0, cc} + 13'd1;
    rc_inc = {1'b0, rc} + 13'd1;
    cp_inc = {1'b0, cp} + 5'd1;
    rp_inc = {1'b0, rp} + 5'd1;

    column_count_next = cc_inc[11:0];
    column_phase_next = (cp_inc >= st) ? 4'd0 : cp_inc[3:0];
    row_count_next    = rc;
    row_phase_next    = rp;
    if (cc_inc >= w) begin
      column_count_next = '0;
      column_phase_next = '0;
      row_count_next    = rc_inc[11:0];
      row_phase_next    = (rp_inc >= st) ? 4'd0 : rp_inc[3:0];
      if (rc_inc >= h) begin
        row_count_next = '0;
        row_phase_next = '0;
      end
    end
  end

  always_comb begin
    kept     = (cp == '0) && (rp == '0);
    in_range = (depth_mm > 16'(MIN_DEPTH_MM)) && (depth_mm <= 16'(MAX_DEPTH_MM));
    off_x    = {1'b0, cc, 4'b0000} - {1'b0, cfg.center_x};
    off_y    = {1'b0, rc, 4'b0000} - {1'b0, cfg.center_y};
    neg_off_x = 17'd0 - off_x;
    neg_off_y = 17'd0 - off_y;

    push_data.neg_x = off_x[16];
    push_data.mag_x = off_x[16] ? neg_off_x[15:0] : off_x[15:0];
    push_data.neg_y = off_y[16];
    push_data.mag_y = off_y[16] ? neg_off_y[15:0] : off_y[15:0];
    push_data.depth = depth_mm;
    push_data.red   = red;
    push_data.green = green;
    push_data.blue  = blue;
    push_data.valid = in_range;
    push_data.last  = (({1'b0, cc} + 13'(st)) >= w) && (({1'b0, rc} + 13'(st)) >= h);
  end

  assign push = accept && kept;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      column_phase <= '0;
      row_phase    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      column_phase <= column_phase_next;
      row_phase    <= row_phase_next;
    end
  end

endmodule

/* design/dpb_queue.sv */
// Short request queue between the front and back parts.
// Depends on dpb_pkg for the request type and depth.
module dpb_queue
  import dpb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  point_req_t push_data,
  input  logic       pop,
  output point_req_t head,
  output q_stat_t    q_stat
);

  point_req_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QPTR_W:0]    count;
  logic               do_push, do_pop;

  assign q_stat.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/dpb_back.sv */
// Back part: projection pipeline, offset*depth, times inverse focal, round and saturate.
// Depends on dpb_pkg; pops requests from dpb_queue and drives the result register.
module dpb_back
  import dpb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  point_req_t         head,
  input  q_stat_t            q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] x_mm,
  output logic signed [23:0] y_mm,
  output logic [15:0]        z_mm,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic               point_valid,
  output logic               frame_end
);

  logic        v1, v2, adv;
  point_req_t  e1, e2;
  logic [31:0] px, py;
  logic [55:0] fx, fy;
  logic [23:0] sx, sy;

  function automatic logic [23:0] round_sat(input logic [55:0] f, input logic neg);
    logic [56:0] rs;
    logic [28:0] r;
    logic [23:0] res;
    rs = {1'b0, f} + (57'd1 << 27);
    r  = rs[56:28];
    if (neg) begin
      res = (r > 29'd8388608) ? 24'h800000 : 24'(29'd0 - r);
    end else begin
      res = (r > 29'd8388607) ? 24'h7FFFFF : r[23:0];
    end
    return res;
  endfunction

  assign adv = !out_valid || out_ready;
  assign pop = adv && !q_stat.empty;

  assign sx = round_sat(fx, e2.neg_x);
  assign sy = round_sat(fy, e2.neg_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= pop;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1 <= head;
      px <= 32'(head.mag_x) * 32'(head.depth);
      py <= 32'(head.mag_y) * 32'(head.depth);
      e2 <= e1;
      fx <= 56'(px) * 56'(cfg.inv_focal_x);
      fy <= 56'(py) * 56'(cfg.inv_focal_y);
      x_mm        <= e2.valid ? sx : '0;
      y_mm        <= e2.valid ? sy : '0;
      z_mm        <= e2.valid ? e2.depth : '0;
      out_red     <= e2.valid ? e2.red : '0;
      out_green   <= e2.valid ? e2.green : '0;
      out_blue    <= e2.valid ? e2.blue : '0;
      point_valid <= e2.valid;
      frame_end   <= e2.last;
    end
  end

endmodule

/* design/depth_pixel_backprojection.sv */
// Top level of the depth pixel back-projection block: registers, front, queue, back.
// Depends on dpb_pkg, dpb_front, dpb_queue and dpb_back.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    depth_mm, red, green, blue, frame_start
//   out      out_valid / out_ready  x_mm, y_mm, z_mm, out_red/green/blue, point_valid, frame_end
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel a cycle while the request queue has room; a kept pixel goes from the queue
// through the two multiplier stages and the rounding stage to the output register. Reset
// is synchronous and clears counters, queue and pipeline valids. A stalled output freezes
// the back pipeline; the front keeps taking pixels until the 4-entry request queue fills.
module depth_pixel_backprojection
  import dpb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        depth_mm,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] x_mm,
  output logic signed [23:0] y_mm,
  output logic [15:0]        z_mm,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic               point_valid,
  output logic               frame_end,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  cfg_t       cfg;
  q_stat_t    q_stat;
  logic       push, pop;
  point_req_t push_data, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= 13'd640;
      cfg.image_height <= 13'd480;
      cfg.stride       <= 5'd3;
      cfg.inv_focal_x  <= 24'd30190;
      cfg.inv_focal_y  <= 24'd30195;
      cfg.center_x     <= 16'd5548;
      cfg.center_y     <= 16'd3837;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[12:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[12:0];
        REG_STRIDE:       cfg.stride       <= cfg_data[4:0];
        REG_INV_FOCAL_X:  cfg.inv_focal_x  <= cfg_data;
        REG_INV_FOCAL_Y:  cfg.inv_focal_y  <= cfg_data;
        REG_CENTER_X:     cfg.center_x     <= cfg_data[15:0];
        REG_CENTER_Y:     cfg.center_y     <= cfg_data[15:0];
        default:          cfg              <= cfg;
      endcase
    end
  end

  dpb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .depth_mm    (depth_mm),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .frame_start (frame_start),
    .q_stat      (q_stat),
    .push        (push),
    .push_data   (push_data)
  );

  dpb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  dpb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .x_mm        (x_mm),
    .y_mm        (y_mm),
    .z_mm        (z_mm),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .point_valid (point_valid),
    .frame_end   (frame_end)
  );

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !point_valid |-> x_mm == 0 && y_mm == 0 && z_mm == 0)
    else $error("invalid point carries nonzero coordinates");

  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && point_valid |->
      z_mm > 16'(MIN_DEPTH_MM) && z_mm <= 16'(MAX_DEPTH_MM))
    else $error("valid point outside depth range");

  a_queue_stat: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty) && (in_ready == !q_stat.full))
    else $error("request queue status inconsistent");

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// Testbench for depth_pixel_backprojection: streams pixel rasters under several register
// setups, predicts every kept point and checks the output stream point by point.
// Depends on dpb_pkg and the depth_pixel_backprojection RTL.
module tb;
  import dpb_pkg::*;

  typedef struct packed {
    logic [15:0] depth;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        frame_start;
  } pixel_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [15:0]        z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               valid;
    logic               last;
  } point_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [15:0]        depth_mm = '0;
  logic [7:0]         red = '0;
  logic [7:0]         green = '0;
  logic [7:0]         blue = '0;
  logic               frame_start = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [23:0] x_mm;
  logic signed [23:0] y_mm;
  logic [15:0]        z_mm;
  logic [7:0]         out_red;
  logic [7:0]         out_green;
  logic [7:0]         out_blue;
  logic               point_valid;
  logic               frame_end;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [23:0]        cfg_data = '0;

  depth_pixel_backprojection dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .depth_mm(depth_mm), .red(red), .green(green), .blue(blue), .frame_start(frame_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .x_mm(x_mm), .y_mm(y_mm), .z_mm(z_mm),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .point_valid(point_valid), .frame_end(frame_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pixel_t      pixel_queue[$];
  point_t      expected_points[$];
  pixel_t      sent_px;
  cfg_t        model_cfg = '{image_width: 13'd640, image_height: 13'd480, stride: 5'd3,
                             inv_focal_x: 24'd30190, inv_focal_y: 24'd30195,
                             center_x: 16'd5548, center_y: 16'd3837};
  logic [11:0] x_pos = '0;
  logic [11:0] y_pos = '0;
  logic [3:0]  x_phase = '0;
  logic [3:0]  y_phase = '0;
  int unsigned pixel_gap = 0;
  int unsigned point_stall = 0;
  int unsigned mismatch_count = 0;
  bit          calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned bound_reg(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [23:0] project_mm(input logic [11:0] pos, input logic [15:0] ctr,
                                             input logic [15:0] depth, input logic [23:0] inv);
    logic signed [18:0] off;
    logic [15:0]        mag;
    logic [63:0]        prod;
    logic [63:0]        r;
    off = $signed({3'b0, pos, 4'b0}) - $signed({3'b0, ctr});
    mag = (off < 0) ? 16'(-off) : 16'(off);
    prod = 64'(mag) * 64'(depth) * 64'(inv);
    r = (prod + (64'd1 << 27)) >> 28;
    if (off < 0) return (r > 64'd8388608) ? 24'h800000 : 24'(-r);
    return (r > 64'd8388607) ? 24'h7FFFFF : r[23:0];
  endfunction

  function automatic void backproject_pixel(input pixel_t px);
    int unsigned w;
    int unsigned h;
    int unsigned st;
    int unsigned nxt;
    point_t      pt;
    w = bound_reg(model_cfg.image_width, MAX_DIM);
    h = bound_reg(model_cfg.image_height, MAX_DIM);
    st = bound_reg(model_cfg.stride, MAX_STEP);
    if (px.frame_start) begin
      x_pos = '0;
      y_pos = '0;
      x_phase = '0;
      y_phase = '0;
    end
    if (x_phase == 0 && y_phase == 0) begin
      pt = '0;
      pt.valid = px.depth > MIN_DEPTH_MM && px.depth <= MAX_DEPTH_MM;
      pt.last = (x_pos + st >= w) && (y_pos + st >= h);
      if (pt.valid) begin
        pt.x = project_mm(x_pos, model_cfg.center_x, px.depth, model_cfg.inv_focal_x);
        pt.y = project_mm(y_pos, model_cfg.center_y, px.depth, model_cfg.inv_focal_y);
        pt.z = px.depth;
        pt.red = px.red;
        pt.green = px.green;
        pt.blue = px.blue;
      end
      expected_points.push_back(pt);
    end
    nxt = x_pos + 1;
    x_phase = (x_phase + 1 >= st) ? 4'd0 : x_phase + 4'd1;
    if (nxt >= w) begin
      x_pos = '0;
      x_phase = '0;
      nxt = y_pos + 1;
      y_phase = (y_phase + 1 >= st) ? 4'd0 : y_phase + 4'd1;
      if (nxt >= h) begin
        y_pos = '0;
        y_phase = '0;
      end else begin
        y_pos = 12'(nxt);
      end
    end else begin
      x_pos = 12'(nxt);
    end
  endfunction

  always @(posedge clk) begin
    pixel_t px;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) backproject_pixel(sent_px);
      if (!in_valid || in_ready) begin
        if (pixel_gap > 0) begin
          pixel_gap--;
          in_valid <= 1'b0;
        end else if (pixel_queue.size() != 0 && !calm && $urandom_range(0, 11) == 0) begin
          pixel_gap = $urandom_range(0, 14);
          in_valid <= 1'b0;
        end else if (pixel_queue.size() != 0) begin
          px = pixel_queue.pop_front();
          sent_px = px;
          depth_mm <= px.depth;
          red <= px.red;
          green <= px.green;
          blue <= px.blue;
          frame_start <= px.frame_start;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (point_stall > 0) begin
      point_stall--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      point_stall = $urandom_range(0, 14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    point_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unpredicted point x=%0d y=%0d z=%0d valid=%0b end=%0b",
                   $time, x_mm, y_mm, z_mm, point_valid, frame_end);
      end else begin
        want = expected_points.pop_front();
        if (x_mm !== want.x || y_mm !== want.y || z_mm !== want.z ||
            out_red !== want.red || out_green !== want.green || out_blue !== want.blue ||
            point_valid !== want.valid || frame_end !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: point mismatch", $time);
            $display("  expected x=%0d y=%0d z=%0d rgb=%0d/%0d/%0d valid=%0b end=%0b",
                     want.x, want.y, want.z, want.red, want.green, want.blue,
                     want.valid, want.last);
            $display("  actual   x=%0d y=%0d z=%0d rgb=%0d/%0d/%0d valid=%0b end=%0b",
                     x_mm, y_mm, z_mm, out_red, out_green, out_blue, point_valid, frame_end);
          end
        end
      end
    end
  end

  function automatic void queue_pixel(input logic [15:0] d, input logic [7:0] r,
                                      input logic [7:0] g, input logic [7:0] b,
                                      input logic fs);
    pixel_queue.push_back('{depth: d, red: r, green: g, blue: b, frame_start: fs});
  endfunction

  function automatic logic [15:0] pick_depth();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(0, 101));
      2: return 16'($urandom_range(49990, 50010));
      default: return 16'($urandom_range(101, 50000));
    endcase
  endfunction

  function automatic logic [23:0] pick_inv();
    case ($urandom_range(0, 7))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(1, 24'hFFFFFF));
      default: return 24'($urandom_range(20000, 40000));
    endcase
  endfunction

  function automatic logic [15:0] pick_center();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 320));
    endcase
  endfunction

  function automatic void random_frames(input int unsigned budget);
    int unsigned sent;
    int unsigned fsz;
    int unsigned len;
    sent = 0;
    while (sent < budget) begin
      fsz = bound_reg(model_cfg.image_width, MAX_DIM) *
            bound_reg(model_cfg.image_height, MAX_DIM);
      case ($urandom_range(0, 9))
        0: len = $urandom_range(1, fsz);
        1: len = fsz + $urandom_range(1, fsz);
        default: len = fsz;
      endcase
      for (int i = 0; i < len; i++)
        queue_pixel(pick_depth(), 8'($urandom), 8'($urandom), 8'($urandom),
                    (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0));
      sent += len;
    end
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_IMAGE_WIDTH:  model_cfg.image_width = val[12:0];
      REG_IMAGE_HEIGHT: model_cfg.image_height = val[12:0];
      REG_STRIDE:       model_cfg.stride = val[4:0];
      REG_INV_FOCAL_X:  model_cfg.inv_focal_x = val;
      REG_INV_FOCAL_Y:  model_cfg.inv_focal_y = val;
      REG_CENTER_X:     model_cfg.center_x = val[15:0];
      REG_CENTER_Y:     model_cfg.center_y = val[15:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [12:0] w, input logic [12:0] h,
                              input logic [4:0] st, input logic [23:0] ifx,
                              input logic [23:0] ify, input logic [15:0] cx,
                              input logic [15:0] cy);
    write_reg(REG_IMAGE_WIDTH, 24'(w));
    write_reg(REG_IMAGE_HEIGHT, 24'(h));
    write_reg(REG_STRIDE, 24'(st));
    write_reg(REG_INV_FOCAL_X, ifx);
    write_reg(REG_INV_FOCAL_Y, ify);
    write_reg(REG_CENTER_X, 24'(cx));
    write_reg(REG_CENTER_Y, 24'(cy));
    cfg_valid <= 1'b0;
  endtask

  task automatic random_setup();
    logic [12:0] w;
    logic [12:0] h;
    logic [4:0]  st;
    case ($urandom_range(0, 9))
      0: w = 13'd0;
      1: w = 13'd1;
      default: w = 13'($urandom_range(2, 20));
    endcase
    case ($urandom_range(0, 9))
      0: h = 13'd0;
      1: h = 13'd1;
      default: h = 13'($urandom_range(2, 10));
    endcase
    case ($urandom_range(0, 9))
      0: st = 5'd0;
      1: st = 5'd31;
      2: st = 5'd16;
      default: st = 5'($urandom_range(1, 4));
    endcase
    program_regs(w, h, st, pick_inv(), pick_inv(), pick_center(), pick_center());
  endtask

  // hold the sender until every predicted point is out, then let the pipe settle
  task automatic drain();
    while (pixel_queue.size() != 0 || in_valid || expected_points.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [15:0] probe_depths [8];
    probe_depths = '{16'd0, 16'd100, 16'd101, 16'd50000, 16'd50001, 16'd65535,
                     16'd1000, 16'd1};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 0)
        queue_pixel(probe_depths[i / 3], ((i / 3) % 2) ? 8'hFF : 8'h00,
                    ((i / 3) % 2) ? 8'h00 : 8'hFF, ((i / 3) % 2) ? 8'hFF : 8'h00,
                    i == 0 || i == 12);
      else
        queue_pixel(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    end
    drain();

    program_regs(13'h1FFF, 13'd0, 5'd31, 24'hFFFFFF, 24'd0, 16'd0, 16'hFFFF);
    for (int i = 0; i < 200; i++)
      queue_pixel(pick_depth(), 8'($urandom), 8'($urandom), 8'($urandom), i == 0);
    drain();

    program_regs(13'd1, 13'd1, 5'd1, 24'd1, 24'hFFFFFF, 16'hFFFF, 16'd0);
    random_frames(40);

    for (int p = 0; p < 7; p++) begin
      drain();
      if (p == 6) calm = 1'b1;
      random_setup();
      random_frames(110);
    end

    drain();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* depth_pixel_backprojection.f */
design/dpb_pkg.sv
design/dpb_front.sv
design/dpb_queue.sv
design/dpb_back.sv
design/depth_pixel_backprojection.sv
dv/tb.sv
